// ===== hw/rtl/mppt_pkg.sv =====
// ----------------------------------------------------------------------------
// mppt_pkg
// Shared constants, payload structs and control structs of the task picker.
// ----------------------------------------------------------------------------
`default_nettype none

package mppt_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TIME_BITS = 24;
	localparam int LEVEL_MAX = 15;

	localparam int IDX_BITS  = $clog2(MAX_TASKS);
	localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
	localparam int LVL_BITS  = $clog2(LEVEL_MAX + 1);
	localparam int SVC_BITS  = 16;
	localparam int ID_BITS   = 16;
	localparam int PROD_BITS = TIME_BITS + 1 + SVC_BITS;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_PICK   = 2'd1;
	localparam logic [1:0] OP_REPORT = 2'd2;

	localparam logic [2:0] POL_RR   = 3'd0;
	localparam logic [2:0] POL_FCFS = 3'd1;
	localparam logic [2:0] POL_SPN  = 3'd2;
	localparam logic [2:0] POL_HRRN = 3'd3;
	localparam logic [2:0] POL_SRT  = 3'd4;
	localparam logic [2:0] POL_FB   = 3'd5;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	typedef struct packed {
		logic [1:0]           op;
		logic [3:0]           task_index;
		logic [ID_BITS-1:0]   task_id;
		logic [TIME_BITS-1:0] arrival_time;
		logic [SVC_BITS-1:0]  total_runtime;
		logic [TIME_BITS-1:0] now;
		logic [SVC_BITS-1:0]  consumed_runtime;
		logic                 finished;
	} task_item_t;

	typedef struct packed {
		logic       pick_valid;
		logic [3:0] picked_index;
		logic       first_dispatch;
		logic       all_done;
	} result_item_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] arrival;
		logic [SVC_BITS-1:0]  service;
		logic [SVC_BITS-1:0]  used;
		logic [ID_BITS-1:0]   ident;
		logic                 done;
		logic [LVL_BITS-1:0]  level;
		logic                 started;
	} slot_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic report;
		logic start;
	} cell_ctl_t;

	typedef struct packed {
		logic clear;
		logic mult;
		logic decide;
	} judge_ctl_t;

	typedef struct packed {
		logic                found;
		logic [IDX_BITS-1:0] index;
	} judge_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_MOD,
		ST_MULT,
		ST_DECIDE,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mppt_cell.sv =====
// ----------------------------------------------------------------------------
// mppt_cell
// One task slot of the ring; shifts its record to the neighbour on a scan step.
// ----------------------------------------------------------------------------
`default_nettype none

module mppt_cell (
	input  wire logic                            clk,
	input  wire mppt_pkg::cell_ctl_t             ctl,
	input  wire logic                            sel,
	input  wire mppt_pkg::slot_t                 next_rec,
	input  wire mppt_pkg::slot_t                 load_rec,
	input  wire logic [mppt_pkg::SVC_BITS-1:0]   rep_used,
	input  wire logic                            rep_fin,
	output mppt_pkg::slot_t                      rec
);

	mppt_pkg::slot_t rec_q;

	assign rec = rec_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			rec_q <= next_rec;
		end else if (sel && ctl.load) begin
			rec_q <= load_rec;
		end else if (sel && ctl.report) begin
			rec_q.used <= rep_used;
			rec_q.done <= rep_fin;
			// The level saturates at its ceiling.
			if (!rep_fin && (32'(rec_q.level) < mppt_pkg::LEVEL_MAX)) begin
				rec_q.level <= rec_q.level + 1'b1;
			end
		end else if (sel && ctl.start) begin
			rec_q.started <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mppt_judge.sv =====
// ----------------------------------------------------------------------------
// mppt_judge
// Head of the ring: compares the slot at the head against the best so far.
// ----------------------------------------------------------------------------
`default_nettype none

module mppt_judge (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire mppt_pkg::judge_ctl_t             ctl,
	input  wire mppt_pkg::slot_t                  head,
	input  wire logic [mppt_pkg::CNT_BITS-1:0]    step,
	input  wire logic [mppt_pkg::CNT_BITS-1:0]    n,
	input  wire logic [mppt_pkg::IDX_BITS-1:0]    start,
	input  wire logic [mppt_pkg::TIME_BITS-1:0]   now,
	input  wire logic [2:0]                       policy,
	output mppt_pkg::judge_res_t                  res
);

	mppt_pkg::slot_t                   best_q;
	logic [mppt_pkg::IDX_BITS-1:0]     best_idx_q;
	logic                              found_q;
	logic [mppt_pkg::IDX_BITS-1:0]     hi_idx_q;
	logic                              hi_found_q;
	logic [mppt_pkg::PROD_BITS-1:0]    pa_s1;
	logic [mppt_pkg::PROD_BITS-1:0]    pb_s1;

	logic [mppt_pkg::SVC_BITS-1:0]     sa;
	logic [mppt_pkg::SVC_BITS-1:0]     sb;
	logic [mppt_pkg::TIME_BITS:0]      na;
	logic [mppt_pkg::TIME_BITS:0]      nb;
	logic [mppt_pkg::SVC_BITS-1:0]     rem_a;
	logic [mppt_pkg::SVC_BITS-1:0]     rem_b;
	logic                              ready;
	logic                              better;
	logic                              arr_lt;
	logic                              arr_eq;
	logic [mppt_pkg::IDX_BITS-1:0]     k;

	assign k = step[mppt_pkg::IDX_BITS-1:0];

	always_comb begin
		sa = (head.service == '0) ? mppt_pkg::SVC_BITS'(1) : head.service;
		sb = (best_q.service == '0) ? mppt_pkg::SVC_BITS'(1) : best_q.service;
		na = (mppt_pkg::TIME_BITS + 1)'(now - head.arrival) + (mppt_pkg::TIME_BITS + 1)'(sa);
		nb = (mppt_pkg::TIME_BITS + 1)'(now - best_q.arrival) + (mppt_pkg::TIME_BITS + 1)'(sb);
		rem_a = (head.used >= head.service) ? '0 : head.service - head.used;
		rem_b = (best_q.used >= best_q.service) ? '0 : best_q.service - best_q.used;
		ready = !head.done && (head.arrival <= now) && (step < n);
		arr_lt = head.arrival < best_q.arrival;
		arr_eq = head.arrival == best_q.arrival;
		case (policy)
			mppt_pkg::POL_FCFS: better = arr_lt || (arr_eq && head.ident < best_q.ident);
			mppt_pkg::POL_SPN:  better = (head.service < best_q.service) ||
			                    ((head.service == best_q.service) && arr_lt);
			mppt_pkg::POL_HRRN: better = pa_s1 > pb_s1;
			mppt_pkg::POL_SRT:  better = (rem_a < rem_b) || ((rem_a == rem_b) && arr_lt);
			default:            better = (head.level < best_q.level) ||
			                    ((head.level == best_q.level) && arr_lt);
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mult) begin
			pa_s1 <= mppt_pkg::PROD_BITS'(na) * mppt_pkg::PROD_BITS'(sb);
			pb_s1 <= mppt_pkg::PROD_BITS'(nb) * mppt_pkg::PROD_BITS'(sa);
		end
		if (ctl.decide && ready) begin
			if (policy == mppt_pkg::POL_RR) begin
				if (!found_q) begin
					best_idx_q <= k;
				end
			end else if (!found_q || better) begin
				best_idx_q <= k;
				best_q     <= head;
			end
			if (!hi_found_q && (k >= start)) begin
				hi_idx_q <= k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			hi_found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q    <= 1'b0;
			hi_found_q <= 1'b0;
		end else if (ctl.decide && ready) begin
			found_q <= 1'b1;
			if (k >= start) begin
				hi_found_q <= 1'b1;
			end
		end
	end

	always_comb begin
		res.found = found_q;
		if (policy == mppt_pkg::POL_RR && hi_found_q) begin
			res.index = hi_idx_q;
		end else begin
			res.index = best_idx_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_policy_task_picker.sv =====
// ----------------------------------------------------------------------------
// multi_policy_task_picker
// Scheduler decision unit over a ring of task slot cells.
// ----------------------------------------------------------------------------
// A load or report passes through the apply state to the finish state, where
// its result is registered; an unknown op, or a pick with no slot in use or
// an unknown rule, goes straight to the finish state. A pick turns the ring
// once through the head comparator, with a product step and then a decision
// step per slot, after the pointer reduction state under round robin. One
// item is in flight at a time and the next can be taken the cycle after its
// result is registered. Reset clears control, policy (round robin) and the
// slot count (all slots); slot contents are undefined until loaded.
`default_nettype none

module multi_policy_task_picker (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   task_valid,
	output logic                        task_stall,
	input  wire mppt_pkg::task_item_t   task_item,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output mppt_pkg::result_item_t      result_item,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,
	input  wire logic [4:0]             cfg_data
);

	// Configuration registers.
	logic [2:0] policy_q;
	logic [4:0] task_count_q;

	// Control state.
	mppt_pkg::state_t                  state_q;
	mppt_pkg::state_t                  state_d;
	logic [mppt_pkg::CNT_BITS-1:0]     step_q;
	logic [mppt_pkg::IDX_BITS-1:0]     start_q;
	logic [mppt_pkg::IDX_BITS-1:0]     rot_q;
	logic                              out_valid_q;
	mppt_pkg::result_item_t            out_q;

	// The accepted item is held here for the whole of its work.
	mppt_pkg::task_item_t              item_q;

	logic [mppt_pkg::CNT_BITS-1:0]     n;
	logic                              accept;
	logic                              out_free;
	logic                              finish_xfer;
	logic                              pick_ok;
	logic                              all_done;

	mppt_pkg::cell_ctl_t               cell_ctl;
	mppt_pkg::judge_ctl_t              judge_ctl;
	mppt_pkg::judge_res_t              judge_res;
	mppt_pkg::slot_t                   recs [mppt_pkg::MAX_TASKS];
	mppt_pkg::slot_t                   load_rec;
	logic [mppt_pkg::MAX_TASKS-1:0]    sel;

	// Slots in use: the count saturates at the ring length.
	assign n = (32'(task_count_q) > mppt_pkg::MAX_TASKS) ?
	           mppt_pkg::CNT_BITS'(mppt_pkg::MAX_TASKS) :
	           mppt_pkg::CNT_BITS'(task_count_q);

	assign task_stall   = (state_q != mppt_pkg::ST_IDLE);
	assign accept       = task_valid && !task_stall;
	assign out_free     = !out_valid_q || !result_stall;
	assign finish_xfer  = (state_q == mppt_pkg::ST_FINISH) && out_free;
	assign pick_ok      = (item_q.op == mppt_pkg::OP_PICK) && judge_res.found;
	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= mppt_pkg::POL_RR;
			task_count_q <= 5'd16;
		end else if (cfg_we) begin
			if (cfg_index == mppt_pkg::REG_POLICY) begin
				policy_q <= cfg_data[2:0];
			end else begin
				task_count_q <= cfg_data;
			end
		end
	end

	// A load writes a fresh record: nothing used, not done, never started.
	always_comb begin
		load_rec.arrival = item_q.arrival_time;
		load_rec.service = item_q.total_runtime;
		load_rec.used    = '0;
		load_rec.ident   = item_q.task_id;
		load_rec.done    = 1'b0;
		load_rec.level   = '0;
		load_rec.started = 1'b0;
	end

	always_comb begin
		cell_ctl.shift  = (state_q == mppt_pkg::ST_DECIDE);
		cell_ctl.load   = (state_q == mppt_pkg::ST_APPLY) && (item_q.op == mppt_pkg::OP_LOAD);
		cell_ctl.report = (state_q == mppt_pkg::ST_APPLY) && (item_q.op == mppt_pkg::OP_REPORT);
		cell_ctl.start  = finish_xfer && pick_ok;
		judge_ctl.clear  = (state_q == mppt_pkg::ST_IDLE);
		judge_ctl.mult   = (state_q == mppt_pkg::ST_MULT);
		judge_ctl.decide = (state_q == mppt_pkg::ST_DECIDE);
	end

	// The ring: each cell takes its record from the next one on a scan step,
	// so the slot at the head walks through every slot in index order and
	// the ring is back home after a full turn.
	for (genvar i = 0; i < mppt_pkg::MAX_TASKS; i++) begin : g_ring
		assign sel[i] = (state_q == mppt_pkg::ST_APPLY) ?
		                (32'(item_q.task_index) == i) :
		                (32'(judge_res.index) == i);

		mppt_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.sel      (sel[i]),
			.next_rec (recs[(i + 1) % mppt_pkg::MAX_TASKS]),
			.load_rec (load_rec),
			.rep_used (item_q.consumed_runtime),
			.rep_fin  (item_q.finished),
			.rec      (recs[i])
		);
	end

	mppt_judge u_judge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (judge_ctl),
		.head   (recs[0]),
		.step   (step_q),
		.n      (n),
		.start  (start_q),
		.now    (item_q.now),
		.policy (policy_q),
		.res    (judge_res)
	);

	// Every slot in use finished; the ring is at home when this is read.
	always_comb begin
		all_done = 1'b1;
		for (int i = 0; i < mppt_pkg::MAX_TASKS; i++) begin
			if ((i < 32'(n)) && !recs[i].done) begin
				all_done = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mppt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mppt_pkg::ST_IDLE: begin
				if (accept) begin
					if (task_item.op == mppt_pkg::OP_LOAD ||
					    task_item.op == mppt_pkg::OP_REPORT) begin
						state_d = mppt_pkg::ST_APPLY;
					end else if (task_item.op == mppt_pkg::OP_PICK &&
					             policy_q <= mppt_pkg::POL_FB && n != '0) begin
						state_d = (policy_q == mppt_pkg::POL_RR) ?
						          mppt_pkg::ST_MOD : mppt_pkg::ST_MULT;
					end else begin
						state_d = mppt_pkg::ST_FINISH;
					end
				end
			end
			mppt_pkg::ST_APPLY: state_d = mppt_pkg::ST_FINISH;
			mppt_pkg::ST_MOD: begin
				if (32'(start_q) < 32'(n)) begin
					state_d = mppt_pkg::ST_MULT;
				end
			end
			mppt_pkg::ST_MULT: state_d = mppt_pkg::ST_DECIDE;
			mppt_pkg::ST_DECIDE: begin
				if (32'(step_q) == mppt_pkg::MAX_TASKS - 1) begin
					state_d = mppt_pkg::ST_FINISH;
				end else begin
					state_d = mppt_pkg::ST_MULT;
				end
			end
			mppt_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = mppt_pkg::ST_IDLE;
				end
			end
			default: state_d = mppt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= task_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			start_q     <= '0;
			rot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				step_q  <= '0;
				start_q <= rot_q;
			end
			// The rotate pointer is reduced modulo the slots in use.
			if (state_q == mppt_pkg::ST_MOD && 32'(start_q) >= 32'(n)) begin
				start_q <= start_q - mppt_pkg::IDX_BITS'(n);
			end
			if (state_q == mppt_pkg::ST_DECIDE) begin
				step_q <= step_q + 1'b1;
			end
			if (finish_xfer && pick_ok && policy_q == mppt_pkg::POL_RR) begin
				if (32'(judge_res.index) + 1 == 32'(n)) begin
					rot_q <= '0;
				end else begin
					rot_q <= judge_res.index + 1'b1;
				end
			end
			if (finish_xfer) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish_xfer) begin
			out_q.pick_valid     <= pick_ok;
			out_q.picked_index   <= pick_ok ? 4'(judge_res.index) : 4'd0;
			out_q.first_dispatch <= pick_ok && !recs[judge_res.index].started;
			out_q.all_done       <= all_done;
		end
	end

	// A full turn of the ring always ends in the result state.
	a_turn_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mppt_pkg::ST_DECIDE && 32'(step_q) == mppt_pkg::MAX_TASKS - 1)
		|=> state_q == mppt_pkg::ST_FINISH)
		else $error("scan did not end after a full turn");

	// An empty pick reports slot zero and no first dispatch.
	a_empty_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.pick_valid)
		|-> (out_q.picked_index == 4'd0 && !out_q.first_dispatch))
		else $error("empty pick carries a slot");

	// After a round robin pick the pointer lies within the slots in use.
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(finish_xfer && pick_ok && policy_q == mppt_pkg::POL_RR)
		|=> 32'(rot_q) < 32'($past(n)))
		else $error("rotate pointer out of range");

	// The ring only moves during a scan step.
	a_shift_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.shift |-> (!cell_ctl.load && !cell_ctl.report && !cell_ctl.start))
		else $error("ring shift overlaps a slot write");

endmodule

`default_nettype wire
